// ----- rtl/pbci_pkg.sv -----
`default_nettype none

package pbci_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
	localparam int COLOR_W = 24;
	localparam int OUT_IDX_W = 8;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic hit_done;
		logic miss_done;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_end;
	} sts_t;

	function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [CNT_W-1:0] n);
		logic [CNT_W+OUT_IDX_W-1:0] ext;
		ext = {{OUT_IDX_W{1'b0}}, n};
		return ext[OUT_IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pbci_ram.sv -----
`default_nettype none

module pbci_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/pbci_ctrl.sv -----
`default_nettype none

module pbci_ctrl
	import pbci_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.hit_done = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.scan_end) begin
					cmd.miss_done = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/pbci_datapath.sv -----
`default_nettype none

module pbci_datapath
	import pbci_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           red,
	input  wire logic [7:0]           green,
	input  wire logic [7:0]           blue,
	input  wire logic                 first_pixel,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	output logic                      done,
	output logic [OUT_IDX_W-1:0]      color_index,
	output logic                      added,
	output logic                      palette_full
);

	logic [COLOR_W-1:0] color_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   addr_s1;
	logic               vld_s1;
	logic               done_q;
	logic [OUT_IDX_W-1:0] index_q;
	logic               added_q;
	logic               full_q;

	logic               rd_issue;
	logic               is_full;
	logic               wr_en;
	logic [COLOR_W-1:0] rd_data;

	assign rd_issue = cmd.scan && (idx_q < count_q);
	assign is_full = (count_q == CNT_W'(PALETTE_ENTRIES));
	assign wr_en = cmd.miss_done && !is_full;

	assign sts.hit = vld_s1 && (rd_data == color_q);
	assign sts.scan_end = !vld_s1 && (idx_q == count_q);

	pbci_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(color_q),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.hit_done || cmd.miss_done;
			if (cmd.load) begin
				vld_s1 <= 1'b0;
				if (first_pixel) begin
					count_q <= '0;
				end
			end else begin
				vld_s1 <= rd_issue;
				if (wr_en) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q <= {red, green, blue};
			idx_q <= '0;
		end else if (rd_issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		addr_s1 <= idx_q;
		if (cmd.hit_done) begin
			index_q <= to_out_index(addr_s1);
			added_q <= 1'b0;
			full_q <= 1'b0;
		end else if (cmd.miss_done) begin
			index_q <= is_full ? '0 : to_out_index(count_q);
			added_q <= !is_full;
			full_q <= is_full;
		end
	end

	assign done = done_q;
	assign color_index = index_q;
	assign added = added_q;
	assign palette_full = full_q;

endmodule

`default_nettype wire

// ----- rtl/palette_builder_color_indexer_top.sv -----
// Each pixel beat is taken when start is high and busy is low; its result comes back
// on done for exactly one cycle and cannot be held off, so it must be captured then.
// The palette is searched one entry per cycle through the registered read port of the
// color RAM, lowest index first: a pixel that matches entry k is answered once entry k
// has been read, and a pixel that matches nothing is answered after all used entries,
// where used is the number of filled entries (none when the palette is empty, at most
// 256 entries). Busy stays high for that whole search and drops as the result is
// registered.
`default_nettype none

module palette_builder_color_indexer_top
	import pbci_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       first_pixel,
	output logic            done,
	output logic [7:0]      color_index,
	output logic            added,
	output logic            palette_full
);

	cmd_t cmd;
	sts_t sts;

	pbci_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.sts   (sts)
	);

	pbci_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.first_pixel (first_pixel),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.color_index (color_index),
		.added       (added),
		.palette_full(palette_full)
	);

endmodule

`default_nettype wire

// ----- dv/palette_builder_color_indexer_top_test.sv -----
`default_nettype none

module palette_builder_color_indexer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pbci_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 340;

	typedef struct {
		logic [OUT_IDX_W-1:0] idx;
		logic                 added;
		logic                 full;
	} pixel_index_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       first_pixel;
	logic       done;
	logic [7:0] color_index;
	logic       added;
	logic       palette_full;

	logic [COLOR_W-1:0] pal_colors [PALETTE_ENTRIES];
	int                 pal_used;
	pixel_index_t       index_queue [$];
	pixel_index_t       want;
	int                 errors;
	int                 quiet_cycles;
	int                 idle_pct;

	palette_builder_color_indexer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.first_pixel (first_pixel),
		.done        (done),
		.color_index (color_index),
		.added       (added),
		.palette_full(palette_full)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Mirrors the palette search and append for one accepted pixel beat.
	task automatic index_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic fp);
		logic [COLOR_W-1:0] c;
		pixel_index_t       res;
		int                 hit;
		c = {r, g, b};
		hit = -1;
		if (fp)
			pal_used = 0;
		for (int k = 0; k < pal_used; k++)
			if (hit < 0 && pal_colors[k] == c)
				hit = k;
		if (hit >= 0) begin
			res = '{hit[7:0], 1'b0, 1'b0};
		end else if (pal_used < PALETTE_ENTRIES) begin
			pal_colors[pal_used] = c;
			res = '{pal_used[7:0], 1'b1, 1'b0};
			pal_used++;
		end else begin
			res = '{8'd0, 1'b0, 1'b1};
		end
		index_queue.push_back(res);
	endtask

	task automatic send_pixel(input logic [COLOR_W-1:0] c, input logic fp);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		red <= c[23:16];
		green <= c[15:8];
		blue <= c[7:0];
		first_pixel <= fp;
		do
			@(posedge clk);
		while (busy);
		index_pixel(c[23:16], c[15:8], c[7:0], fp);
	endtask

	function automatic logic [COLOR_W-1:0] fill_color(input int i);
		logic [7:0] v;
		v = i[7:0];
		return {v, ~v, v ^ 8'h5A};
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (index_queue.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				want = index_queue.pop_front();
				if (color_index !== want.idx)
					report_mismatch($sformatf("color_index %0d, want %0d", color_index, want.idx));
				if (added !== want.added)
					report_mismatch($sformatf("added %0b, want %0b", added, want.added));
				if (palette_full !== want.full)
					report_mismatch($sformatf("palette_full %0b, want %0b", palette_full,
						want.full));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'hFF0000, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'h0000FF, 1'b0);
		send_pixel(24'hFF0000, 1'b0);
		send_pixel(24'hAA55AA, 1'b0);
		send_pixel(24'h55AA55, 1'b0);
		send_pixel(24'h000001, 1'b0);
		send_pixel(24'h800000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h0000FF, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h123456, 1'b1);
		send_pixel(24'h123456, 1'b1);
	endtask

	// Fills all entries, then checks misses on a full palette, hits at both
	// ends, and a new image clearing a full palette.
	task automatic test_full_palette();
		idle_pct = 0;
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			send_pixel(fill_color(i), i == 0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(fill_color(PALETTE_ENTRIES - 1), 1'b0);
		send_pixel(fill_color(0), 1'b0);
		send_pixel(fill_color(128) ^ 24'h000100, 1'b0);
		send_pixel(fill_color(77), 1'b0);
		send_pixel(24'h000000, 1'b1);
		send_pixel(fill_color(200), 1'b0);
	endtask

	task automatic test_random_images();
		int                 pct [3] = '{0, 83, 13};
		int                 sent;
		int                 len;
		int                 reuse_pct;
		int                 sel;
		logic               fp;
		logic [COLOR_W-1:0] c;
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = pct[ph];
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if (ph == 0 && sent == 0) begin
					len = $urandom_range(300, 280);
					reuse_pct = 10;
				end else begin
					len = $urandom_range(100, 1);
					reuse_pct = $urandom_range(85, 40);
				end
				for (int n = 0; n < len && sent < ITEMS_PER_PHASE; n++) begin
					fp = (n == 0) || ($urandom_range(99) < 2);
					sel = $urandom_range(99);
					c = COLOR_W'($urandom());
					if (pal_used > 0 && sel < reuse_pct)
						c = pal_colors[$urandom_range(pal_used - 1)];
					else if (pal_used > 0 && sel < reuse_pct + 10)
						c = pal_colors[$urandom_range(pal_used - 1)] ^
							(24'd1 << $urandom_range(COLOR_W - 1));
					send_pixel(c, fp);
					sent++;
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		red = 8'd0;
		green = 8'd0;
		blue = 8'd0;
		first_pixel = 1'b0;
		pal_used = 0;
		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_palette();
		test_random_images();
		start <= 1'b0;
		while (index_queue.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
